[rtl/core/lpsd_pkg.sv]
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants for the length-prefixed stream deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LengthWidth = 2 * ByteWidth;

  // Status codes carried on the result channel
  localparam logic StatusPayload   = 1'b0;
  localparam logic StatusZeroLen   = 1'b1;

  // Deframer state, one-hot
  typedef enum logic [3:0] {
    StHeaderHi = 4'b0001,
    StHeaderLo = 4'b0010,
    StPayload  = 4'b0100,
    StHalted   = 4'b1000
  } lpsd_state_e;

  // One result item
  typedef struct packed {
    logic [ByteWidth-1:0] payload_byte;
    logic                 end_of_frame;
    logic                 status;
  } lpsd_result_t;

endpackage

[rtl/core/lpsd_if.sv]
// ----------------------------------------------------------------------------
// lpsd_if
// Valid/ready channels of the deframer: byte input and result output.
// ----------------------------------------------------------------------------
interface lpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_frame;
  logic       status;

  modport source (output valid, output payload_byte, output end_of_frame,
                  output status, input ready);
  modport sink   (input valid, input payload_byte, input end_of_frame,
                  input status, output ready);
endinterface

[rtl/core/lpsd_core.sv]
// ----------------------------------------------------------------------------
// lpsd_core
// Frame state machine: parses the two-byte length header, counts payload
// bytes and flags the last one; halts on a zero length.
// ----------------------------------------------------------------------------
module lpsd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [lpsd_pkg::ByteWidth-1:0] byte_i,
  output logic                           res_valid_o,
  output lpsd_pkg::lpsd_result_t         res_o
);
  import lpsd_pkg::*;

  lpsd_state_e            state_q, state_d;
  logic [ByteWidth-1:0]   len_hi_q, len_hi_d;
  logic [LengthWidth-1:0] remaining_q, remaining_d;
  logic [LengthWidth-1:0] length;

  assign length = {len_hi_q, byte_i};

  // Next state and result for the byte being processed; res_valid_o tells
  // whether this byte needs a result slot, independent of step_i
  always_comb begin
    state_d              = state_q;
    len_hi_d             = len_hi_q;
    remaining_d          = remaining_q;
    res_valid_o          = 1'b0;
    res_o.payload_byte   = byte_i;
    res_o.end_of_frame   = 1'b0;
    res_o.status         = StatusPayload;
    unique case (state_q)
      StHeaderHi: begin
        len_hi_d = byte_i;
        state_d  = StHeaderLo;
      end
      StHeaderLo: begin
        if (length == '0) begin
          // zero length: one error result, then halt
          state_d            = StHalted;
          res_valid_o        = 1'b1;
          res_o.payload_byte = '0;
          res_o.status       = StatusZeroLen;
        end else begin
          remaining_d = length;
          state_d     = StPayload;
        end
      end
      StPayload: begin
        remaining_d = remaining_q - LengthWidth'(1);
        res_valid_o = 1'b1;
        if (remaining_q == LengthWidth'(1)) begin
          res_o.end_of_frame = 1'b1;
          state_d            = StHeaderHi;
        end
      end
      StHalted: begin
        // input dropped, nothing changes
      end
      default: begin
        state_d = StHeaderHi;
      end
    endcase
  end

  // State registers, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StHeaderHi;
      len_hi_q    <= '0;
      remaining_q <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      len_hi_q    <= len_hi_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

[rtl/core/length_prefixed_stream_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_stream_deframer
// Splits a byte stream into frames with a 16-bit big-endian length prefix.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one stream byte per transfer (valid/ready). Header bytes give
//           no result.
//   out_o : one result per payload byte, end_of_frame on the last byte of a
//           frame, status 0. A zero length yields one result with payload 0
//           and status 1; after it all input is taken and dropped until reset.
// Timing:
//   A byte passes an input register and then a result register. One byte
//   per cycle is sustained while out_o is not stalled.
// Reset:
//   Asynchronous, active low. Empties both registers and puts the parser at
//   the start of a header.
// Stall:
//   While out_o is stalled the result register holds; header and dropped
//   bytes keep flowing. in_i.ready falls only while a waiting byte needs the
//   occupied result register.
// ----------------------------------------------------------------------------
module length_prefixed_stream_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpsd_in_if.sink    in_i,
  lpsd_out_if.source out_o
);
  import lpsd_pkg::*;

  logic                 in_valid_q;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 out_valid_q, out_valid_d;
  lpsd_result_t         out_res_q;

  logic                 res_valid;
  lpsd_result_t         res;
  logic                 out_free;
  logic                 advance;

  lpsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Pipeline control: a byte leaves the input register when its result,
  // if any, has room
  always_comb begin
    out_free = !out_valid_q || out_o.ready;
    advance  = in_valid_q && (out_free || !res_valid);
  end

  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.stream_byte;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = out_res_q.payload_byte;
  assign out_o.end_of_frame = out_res_q.end_of_frame;
  assign out_o.status       = out_res_q.status;

endmodule

[test/tb_length_prefixed_stream_deframer.sv]
// ----------------------------------------------------------------------------
// tb_length_prefixed_stream_deframer
// Self-checking bench for the length-prefixed deframer. A queue of stream
// bytes (short directed frames, random frames, then a zero length and
// trailing bytes) feeds a clocked driver. A frame parser in the bench
// predicts each result, and a clocked monitor compares every result transfer
// with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_length_prefixed_stream_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import lpsd_pkg::*;

  logic clk_i;
  logic rst_ni;

  lpsd_in_if  in_if ();
  lpsd_out_if out_if ();

  length_prefixed_stream_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and prediction stores
  logic [7:0]   stream_q[$];
  lpsd_result_t expected_q[$];
  int unsigned  mismatches;
  int unsigned  cycle_cnt;

  // Parser state of the bench
  logic        in_frame;
  logic        want_len_lo;
  logic [7:0]  len_hi;
  logic [15:0] bytes_left;
  logic        halted;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Idle at random with a chance of about 35 percent, except for a quiet stretch
  function automatic logic idle_now();
    if (cycle_cnt >= 300 && cycle_cnt < 700) return 1'b0;
    return $urandom_range(0, 99) < 35;
  endfunction

  // Frame parser: expected result for one accepted stream byte
  function automatic void deframe_byte(input logic [7:0] b);
    lpsd_result_t res;
    logic [15:0]  len;
    if (halted) return;
    if (!in_frame) begin
      if (!want_len_lo) begin
        len_hi      = b;
        want_len_lo = 1'b1;
      end else begin
        want_len_lo = 1'b0;
        len         = {len_hi, b};
        if (len == '0) begin
          // zero length: one error result, then everything is dropped
          halted           = 1'b1;
          res.payload_byte = '0;
          res.end_of_frame = 1'b0;
          res.status       = StatusZeroLen;
          expected_q.push_back(res);
        end else begin
          bytes_left = len;
          in_frame   = 1'b1;
        end
      end
    end else begin
      bytes_left       = bytes_left - 16'd1;
      res.payload_byte = b;
      res.end_of_frame = (bytes_left == '0);
      res.status       = StatusPayload;
      if (bytes_left == '0) in_frame = 1'b0;
      expected_q.push_back(res);
    end
  endfunction

  // Header plus random payload
  function automatic void add_frame(input int unsigned flen);
    logic [15:0] len;
    len = flen[15:0];
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    for (int unsigned k = 0; k < flen; k++) begin
      stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Driver: one stream byte per transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.stream_byte);
      end
      if (!in_if.valid || in_if.ready) begin
        if (stream_q.size() != 0 && !idle_now()) begin
          in_if.valid       <= 1'b1;
          in_if.stream_byte <= stream_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    lpsd_result_t exp_res;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("unexpected result: byte %02h eof %0b status %0b",
                     out_if.payload_byte, out_if.end_of_frame, out_if.status);
          end
        end else begin
          exp_res = expected_q.pop_front();
          if (out_if.payload_byte !== exp_res.payload_byte ||
              out_if.end_of_frame !== exp_res.end_of_frame ||
              out_if.status !== exp_res.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result mismatch: exp byte %02h eof %0b status %0b, got %02h %0b %0b",
                       exp_res.payload_byte, exp_res.end_of_frame, exp_res.status,
                       out_if.payload_byte, out_if.end_of_frame, out_if.status);
            end
          end
        end
      end
      out_if.ready <= !idle_now();
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("[length_prefixed_stream_deframer] ERROR");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned rand_items;
    int unsigned pick;
    int unsigned flen;

    in_if.valid       = 1'b0;
    in_if.stream_byte = '0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    mismatches        = 0;
    cycle_cnt         = 0;
    in_frame          = 1'b0;
    want_len_lo       = 1'b0;
    len_hi            = '0;
    bytes_left        = '0;
    halted            = 1'b0;

    // Directed: single-byte frames at the byte extremes, short frames
    stream_q = '{8'h00, 8'h01, 8'h00,
                 8'h00, 8'h01, 8'hFF,
                 8'h00, 8'h03, 8'hAA, 8'h55, 8'h01,
                 8'h00, 8'h02, 8'h80, 8'h7F};

    // Random frames, mostly short, a few spanning several hundred bytes
    rand_items = 0;
    while (rand_items < 610) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      flen = $urandom_range(1, 16);
      else if (pick < 95) flen = $urandom_range(17, 64);
      else                flen = $urandom_range(65, 600);
      add_frame(flen);
      rand_items += flen + 2;
    end

    // The fatal zero length and bytes that get dropped
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    for (int k = 0; k < 20; k++) begin
      stream_q.push_back(8'($urandom_range(0, 255)));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (stream_q.size() == 0 && !in_if.valid);
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[length_prefixed_stream_deframer] OK");
    end else begin
      $display("[length_prefixed_stream_deframer] ERROR");
    end
    $finish;
  end

endmodule
